// ----- rtl/bdpc_pkg.sv -----
// shared types and constants for the button debounce and press classifier
// no dependencies
`timescale 1ns / 1ps

package bdpc_pkg;

  localparam int REG_WIDTH   = 16;
  localparam int IDX_WIDTH   = 1;
  localparam int TDATA_WIDTH = 8;

  localparam logic [REG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [REG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_DEBOUNCE_TICKS   = 1'b0,
    REG_LONG_PRESS_TICKS = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [REG_WIDTH-1:0] debounce_ticks;
    logic [REG_WIDTH-1:0] long_press_ticks;
  } cfg_t;

  // lowest bit last in declaration order
  typedef struct packed {
    logic held_long;
    logic held_short;
    logic debounced_down;
    logic long_press_pulse;
    logic short_press_pulse;
  } result_t;

endpackage

// ----- rtl/bdpc_cfg.sv -----
// configuration register file for the press classifier
// depends on bdpc_pkg
`timescale 1ns / 1ps

module bdpc_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bdpc_pkg::IDX_WIDTH-1:0]    cfg_index,
  input  logic [bdpc_pkg::REG_WIDTH-1:0]    cfg_data,
  output bdpc_pkg::cfg_t                    cfg
);
  import bdpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= DEBOUNCE_RESET;
      cfg.long_press_ticks <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_DEBOUNCE_TICKS:   cfg.debounce_ticks   <= cfg_data;
        REG_LONG_PRESS_TICKS: cfg.long_press_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/bdpc_core.sv -----
// debounce state, saturating counters and press classification for one tick
// depends on bdpc_pkg
`timescale 1ns / 1ps

module bdpc_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                raw_level,
  input  bdpc_pkg::cfg_t      cfg,
  output bdpc_pkg::result_t   res
);
  import bdpc_pkg::*;

  localparam int CMPW = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic                   previous_raw;
  logic                   accepted_level;
  logic [COUNT_WIDTH-1:0] stable_ticks;
  logic [COUNT_WIDTH-1:0] held_ticks;

  logic                   previous_raw_next;
  logic                   accepted_level_next;
  logic [COUNT_WIDTH-1:0] stable_ticks_next;
  logic [COUNT_WIDTH-1:0] held_ticks_next;

  logic [COUNT_WIDTH-1:0] held_inc;
  logic [CMPW-1:0]        deb_ext;
  logic [CMPW-1:0]        long_ext;
  logic [CMPW-1:0]        stable_ext;
  logic [CMPW-1:0]        held_inc_ext;
  logic [CMPW-1:0]        held_next_ext;
  logic                   accept;
  logic                   release_long;
  logic                   down;

  always_comb begin
    held_inc = (held_ticks == COUNT_MAX) ? held_ticks : held_ticks + 1'b1;
    if (raw_level != previous_raw) begin
      stable_ticks_next = '0;
    end else begin
      stable_ticks_next = (stable_ticks == COUNT_MAX) ? stable_ticks : stable_ticks + 1'b1;
    end

    deb_ext      = CMPW'(cfg.debounce_ticks);
    long_ext     = CMPW'(cfg.long_press_ticks);
    stable_ext   = CMPW'(stable_ticks_next);
    held_inc_ext = CMPW'(held_inc);

    accept              = (stable_ext > deb_ext) && (raw_level != accepted_level);
    accepted_level_next = accept ? raw_level : accepted_level;
    held_ticks_next     = (accept && !raw_level) ? '0 : held_inc;
    previous_raw_next   = raw_level;
    held_next_ext       = CMPW'(held_ticks_next);

    release_long = held_inc_ext >= long_ext;
    down         = !accepted_level_next;

    res.long_press_pulse  = accept && raw_level && release_long;
    res.short_press_pulse = accept && raw_level && !release_long && (held_inc_ext >= deb_ext);
    res.debounced_down    = down;
    res.held_short        = down && (held_next_ext < long_ext);
    res.held_long         = down && (held_next_ext >= long_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw   <= 1'b1;
      accepted_level <= 1'b1;
      stable_ticks   <= '0;
      held_ticks     <= '0;
    end else if (en) begin
      previous_raw   <= previous_raw_next;
      accepted_level <= accepted_level_next;
      stable_ticks   <= stable_ticks_next;
      held_ticks     <= held_ticks_next;
    end
  end

`ifndef SYNTHESIS
  // a release pulse only comes with a pressed-to-released change
  assert property (@(posedge clk) disable iff (rst)
    en && (res.short_press_pulse || res.long_press_pulse)
      |=> accepted_level && !$past(accepted_level))
    else $error("release pulse without debounced release");

  // a raw edge restarts the stability count
  assert property (@(posedge clk) disable iff (rst)
    en && (raw_level != previous_raw) |=> stable_ticks == '0)
    else $error("stable count not cleared on raw edge");

  // state only moves on a transaction
  assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(accepted_level) && $stable(held_ticks) && $stable(stable_ticks))
    else $error("state changed without transaction");

  // pulses only while the debounced level shows released
  assert property (@(posedge clk) disable iff (rst)
    en && (res.short_press_pulse || res.long_press_pulse)
      |-> !res.debounced_down && !res.held_short && !res.held_long)
    else $error("pulse while still pressed");
`endif

endmodule

// ----- rtl/button_debounce_press_classifier.sv -----
// One sample tick is taken per cycle when the output is not stalled, and each tick
// gives exactly one result, passing through the input register and then the
// result register. Both counter updates and all threshold compares sit in the
// single stage between those registers, so the sustained rate is one tick per
// clock whenever the downstream side keeps up.
// top level: input stage, classifier core and result register; uses bdpc_pkg
`timescale 1ns / 1ps

module button_debounce_press_classifier #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [bdpc_pkg::TDATA_WIDTH-1:0]    s_tdata,   // raw_level, zero fill
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // short_press_pulse, long_press_pulse, debounced_down, held_short, held_long, zero fill
  output logic [bdpc_pkg::TDATA_WIDTH-1:0]    m_tdata,
  input  logic                                cfg_we,
  input  logic [bdpc_pkg::IDX_WIDTH-1:0]      cfg_index,
  input  logic [bdpc_pkg::REG_WIDTH-1:0]      cfg_data
);
  import bdpc_pkg::*;

  localparam int RES_WIDTH = $bits(result_t);

  cfg_t    cfg;
  result_t res;
  result_t res_hold;
  logic    in_valid;
  logic    in_raw;
  logic    out_valid;
  logic    out_ready;
  logic    advance;

  assign out_ready = !out_valid || m_tready;
  assign s_tready  = !in_valid || out_ready;
  assign advance   = in_valid && out_ready;

  bdpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bdpc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .raw_level (in_raw),
    .cfg       (cfg),
    .res       (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_raw <= s_tdata[0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_hold <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(TDATA_WIDTH-RES_WIDTH){1'b0}}, res_hold};

endmodule
